@@ rtl/mdbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes, reset values and saturation helper for the
// masked depth back-projection block. Depends on nothing.

package mdbp_pkg;

   // Width of the configuration index, wide enough that writes past the
   // last register can be expressed (and are ignored).
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_FOCAL_X = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_FOCAL_Y = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRINCIPAL_POINT = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION        = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSLATION_X   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSLATION_Y   = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSLATION_Z   = 4'd7;

   // Reset values of the registers that do not reset to zero.
   localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
   localparam logic [31:0] ROTATION_RESET  = 32'd16384;

   // Signed Q16.8 limits, held at the width the saturation helper works in.
   localparam logic signed [47:0] Q24_MAX = 48'sd8388607;
   localparam logic signed [47:0] Q24_MIN = -48'sd8388608;

   typedef struct packed {
      logic [9:0] pixel_row;
      logic [9:0] pixel_column;
      logic [7:0] depth;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] bg_red;
      logic [7:0] bg_green;
      logic [7:0] bg_blue;
   } mdbp_req_type;

   typedef struct packed {
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic [7:0]         point_red;
      logic [7:0]         point_green;
      logic [7:0]         point_blue;
   } mdbp_rsp_type;

   // Per-stage load enables for the back-projection stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } mdbp_adv_type;

   // Clamp a sign-extended value to the signed 24-bit range.
   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      logic signed [23:0] r;
      if (v > Q24_MAX) begin
         r = 24'sh7FFFFF;
      end else if (v < Q24_MIN) begin
         r = -24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/mdbp_axis.sv @@
`timescale 1ns / 1ps
// One back-projection axis: offset from the principal point, scaled by depth
// and by the inverse focal length, rounded and saturated. Uses mdbp_pkg.

module mdbp_axis import mdbp_pkg::*; #(
   parameter int CW = 10
) (
   input  logic                clock,
   input  logic [CW-1:0]       coord,
   input  logic [15:0]         centre,
   input  logic [7:0]          depth_s1,
   input  logic [19:0]         inv_focal,
   input  mdbp_adv_type        adv,
   output logic signed [23:0]  result
);

   localparam int SH_W = CW + 4;
   localparam int ND_W = ((SH_W > 16) ? SH_W : 16) + 1;
   localparam int PD_W = ND_W + 9;
   localparam int PF_W = PD_W + 21;
   localparam int RS_W = PF_W + 1 - 16;
   localparam logic signed [PF_W:0] RND16 = (PF_W + 1)'(32768);

   logic signed [ND_W-1:0] nd_ff, nd_in;
   logic signed [PD_W-1:0] pd_ff, pd_in;
   logic signed [PF_W-1:0] pf_ff, pf_in;
   logic signed [23:0]     res_ff, res_in;
   logic signed [PF_W:0]   rnd;
   logic signed [RS_W-1:0] rs;

   // Negated offset: centre minus coordinate, both in Q.4 pixels.
   assign nd_in = signed'(ND_W'(centre)) - signed'(ND_W'({coord, 4'b0000}));
   assign pd_in = nd_ff * signed'({1'b0, depth_s1});
   assign pf_in = pd_ff * signed'({1'b0, inv_focal});
   assign rnd   = (PF_W + 1)'(pf_ff) + RND16;
   assign rs    = signed'(rnd[PF_W:16]);
   assign res_in = sat24(48'(rs));

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         nd_ff <= nd_in;
      end
      if (adv.s2) begin
         pd_ff <= pd_in;
      end
      if (adv.s3) begin
         pf_ff <= pf_in;
      end
      if (adv.s4) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

@@ rtl/masked_depth_backprojection_top.sv @@
`timescale 1ns / 1ps
// Top level of the masked depth back-projection block: registers, foreground
// test, rigid transform and output stage. Uses mdbp_pkg and mdbp_axis.

// One pixel request is taken per clock while req_stall is low, and the block
// runs at a sustained one pixel per cycle while the result channel is not
// stalled; a foreground pixel reaches the result channel through the seven
// register stages of the datapath (colour test and offsets, depth product,
// focal product, rounding, rotation products, rotation sums, translation and
// saturation). A pixel whose background-subtracted value does not exceed the
// threshold is accepted but produces no result, leaving a bubble. Each stage
// holds its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and a stalled output only holds up the stages
// behind it once they are full. Configuration writes are always accepted and
// take effect at once; they are meant to be made while no pixel is in flight.
// Writes to unknown indexes are ignored. ROW_BITS and COLUMN_BITS set how many
// low bits of the row and column are used.

module masked_depth_backprojection_top import mdbp_pkg::*; #(
   parameter int ROW_BITS    = 10,
   parameter int COLUMN_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mdbp_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mdbp_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int FIELD_W = $bits(req_data.pixel_row);
   localparam int ROW_USE = (ROW_BITS < FIELD_W) ? ROW_BITS : FIELD_W;
   localparam int COL_USE = (COLUMN_BITS < FIELD_W) ? COLUMN_BITS : FIELD_W;
   localparam int STAGES  = 7;

   // Configuration registers.
   logic [7:0]         threshold_ff;
   logic [19:0]        ifx_ff, ify_ff;
   logic [31:0]        pp_ff, rot_ff;
   logic signed [23:0] tx_ff, ty_ff, tz_ff;

   // Pipeline control: a valid bit per stage and the load enable of each.
   logic [STAGES:1] vld_ff, vld_in;
   logic [STAGES:1] adv;

   // Foreground test on the incoming request.
   logic [7:0] v_cam, v_bg, v_diff;
   logic       fg;

   // Payload carried alongside the axis units.
   logic [7:0] depth_ff [1:4];
   logic [7:0] red_ff [1:STAGES-1];
   logic [7:0] green_ff [1:STAGES-1];
   logic [7:0] blue_ff [1:STAGES-1];

   logic [ROW_BITS-1:0]    row_c;
   logic [COLUMN_BITS-1:0] col_c;
   mdbp_adv_type           axis_adv;
   logic signed [23:0]     y_s4, z_s4;

   logic signed [16:0] x17;
   logic signed [15:0] cs, sn;
   logic signed [32:0] csx_ff, snx_ff;
   logic signed [39:0] snz_ff, csz_ff;
   logic signed [23:0] y5_ff, y6_ff;
   logic signed [40:0] sum_x, sum_z;
   logic signed [26:0] rx_ff, rz_ff;
   logic signed [27:0] px_w, pz_w;
   logic signed [24:0] py_w;
   mdbp_rsp_type       rsp_ff;

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         ifx_ff       <= '0;
         ify_ff       <= '0;
         pp_ff        <= '0;
         rot_ff       <= ROTATION_RESET;
         tx_ff        <= '0;
         ty_ff        <= '0;
         tz_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VALUE_THRESHOLD: threshold_ff <= csr_data[7:0];
            CSR_INVERSE_FOCAL_X: ifx_ff       <= csr_data[19:0];
            CSR_INVERSE_FOCAL_Y: ify_ff       <= csr_data[19:0];
            CSR_PRINCIPAL_POINT: pp_ff        <= csr_data;
            CSR_ROTATION:        rot_ff       <= csr_data;
            CSR_TRANSLATION_X:   tx_ff        <= signed'(csr_data[23:0]);
            CSR_TRANSLATION_Y:   ty_ff        <= signed'(csr_data[23:0]);
            CSR_TRANSLATION_Z:   tz_ff        <= signed'(csr_data[23:0]);
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------- flow control
   // A stage may load when it is empty or its successor is loading.
   always_comb begin
      logic go;
      go = !vld_ff[STAGES] || !rsp_stall;
      adv[STAGES] = go;
      for (int k = STAGES - 1; k >= 1; k--) begin
         go = !vld_ff[k] || go;
         adv[k] = go;
      end
   end

   assign req_stall = !adv[1];

   // The foreground decision is made on entry, so background pixels never
   // occupy a stage.
   assign v_cam  = max3(req_data.red, req_data.green, req_data.blue);
   assign v_bg   = max3(req_data.bg_red, req_data.bg_green, req_data.bg_blue);
   assign v_diff = (v_cam > v_bg) ? (v_cam - v_bg) : 8'd0;
   assign fg     = v_diff > threshold_ff;

   always_comb begin
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = req_valid && fg;
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------ colour and depth
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         depth_ff[1] <= req_data.depth;
         red_ff[1]   <= req_data.red;
         green_ff[1] <= req_data.green;
         blue_ff[1]  <= req_data.blue;
      end
      for (int k = 2; k < STAGES; k++) begin
         if (adv[k]) begin
            red_ff[k]   <= red_ff[k-1];
            green_ff[k] <= green_ff[k-1];
            blue_ff[k]  <= blue_ff[k-1];
         end
      end
      for (int k = 2; k <= 4; k++) begin
         if (adv[k]) begin
            depth_ff[k] <= depth_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------ back-projection
   // Rows and columns are reduced to their configured widths first.
   assign row_c = ROW_BITS'(req_data.pixel_row[ROW_USE-1:0]);
   assign col_c = COLUMN_BITS'(req_data.pixel_column[COL_USE-1:0]);

   assign axis_adv.s1 = adv[1];
   assign axis_adv.s2 = adv[2];
   assign axis_adv.s3 = adv[3];
   assign axis_adv.s4 = adv[4];

   mdbp_axis #(.CW(COLUMN_BITS)) u_axis_y (
      .clock     (clock),
      .coord     (col_c),
      .centre    (pp_ff[15:0]),
      .depth_s1  (depth_ff[1]),
      .inv_focal (ifx_ff),
      .adv       (axis_adv),
      .result    (y_s4)
   );

   mdbp_axis #(.CW(ROW_BITS)) u_axis_z (
      .clock     (clock),
      .coord     (row_c),
      .centre    (pp_ff[31:16]),
      .depth_s1  (depth_ff[1]),
      .inv_focal (ify_ff),
      .adv       (axis_adv),
      .result    (z_s4)
   );

   // -------------------------------------------------------------- rotation
   // x is the depth itself in Q16.8 and never negative.
   assign x17 = signed'({1'b0, depth_ff[4], 8'b0000_0000});
   assign cs  = signed'(rot_ff[15:0]);
   assign sn  = signed'(rot_ff[31:16]);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         csx_ff <= cs * x17;
         snx_ff <= sn * x17;
         snz_ff <= sn * z_s4;
         csz_ff <= cs * z_s4;
         y5_ff  <= y_s4;
      end
   end

   // Sums are rounded to nearest with ties upwards before dropping 14 bits.
   assign sum_x = 41'(csx_ff) - 41'(snz_ff) + 41'sd8192;
   assign sum_z = 41'(snx_ff) + 41'(csz_ff) + 41'sd8192;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rx_ff <= signed'(sum_x[40:14]);
         rz_ff <= signed'(sum_z[40:14]);
         y6_ff <= y5_ff;
      end
   end

   // ----------------------------------------------------------- translation
   assign px_w = 28'(rx_ff) + 28'(tx_ff);
   assign pz_w = 28'(rz_ff) + 28'(tz_ff);
   assign py_w = 25'(y6_ff) + 25'(ty_ff);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         rsp_ff.point_x     <= sat24(48'(px_w));
         rsp_ff.point_y     <= sat24(48'(py_w));
         rsp_ff.point_z     <= sat24(48'(pz_w));
         rsp_ff.point_red   <= red_ff[6];
         rsp_ff.point_green <= green_ff[6];
         rsp_ff.point_blue  <= blue_ff[6];
      end
   end

   assign rsp_valid = vld_ff[STAGES];
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/mdbp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the masked depth back-projection top level, bound to
// it below. Uses mdbp_pkg.

module mdbp_checker import mdbp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input mdbp_rsp_type rsp_data
);

   // A result held back must stay offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A result held back must not change.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // With nothing waiting at the output the pipeline cannot be full.
   a_no_false_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind masked_depth_backprojection_top mdbp_checker u_mdbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
